>>> rtl/assert_macros.svh
// assertion helpers used by stereo_linear_resampler_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk, quiet while rst is high
`define SLR_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every rising edge of clk, reset included
`define SLR_CHECK_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/slr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slr_pkg
// shared widths, limits and types of the stereo linear resampler
// ---------------------------------------------------------------------------
package slr_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int STEP_W        = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_OUT       = 4;
  localparam int CNT_W         = $clog2(MAX_OUT);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // tag that rides along with the lane product stage
  typedef struct packed {
    logic valid;
    logic last;
  } slr_tag_t;

endpackage

>>> rtl/slr_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slr_in_if
// input frame channel: one stereo frame and its phase step per item
// ---------------------------------------------------------------------------
interface slr_in_if;
  import slr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  logic [STEP_W-1:0]          phase_step;

  modport source (output valid, output left_in, output right_in, output phase_step,
                  input ready);
  modport sink (input valid, input left_in, input right_in, input phase_step,
                output ready);
endinterface

>>> rtl/slr_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slr_out_if
// result channel: one interpolated stereo sample per item
// ---------------------------------------------------------------------------
interface slr_out_if;
  import slr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       out_last;

  modport source (output valid, output out_left, output out_right, output out_last,
                  input ready);
  modport sink (input valid, input out_left, input out_right, input out_last,
                output ready);
endinterface

>>> rtl/slr_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slr_lane
// one channel of the interpolator: prev + (cur - prev) * phase
// ---------------------------------------------------------------------------
module slr_lane #(
  parameter int FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] prev_s,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] cur_s,
  input  logic [FRAC_BITS-1:0]                phase,
  output logic signed [slr_pkg::SAMPLE_W-1:0] y
);
  import slr_pkg::*;

  localparam int DW = SAMPLE_W + 1;
  localparam int TW = DW + FRAC_BITS + 1;
  localparam logic signed [TW-1:0] HI = TW'(SAMPLE_MAX);
  localparam logic signed [TW-1:0] LO = TW'(SAMPLE_MIN);

  logic signed [DW-1:0]        diff;
  logic signed [FRAC_BITS:0]   ph_s;
  logic signed [TW-1:0]        prod_comb;
  logic signed [TW-1:0]        prod;
  logic signed [SAMPLE_W-1:0]  base;
  logic signed [TW-1:0]        t;
  logic signed [TW-1:0]        q;
  logic signed [TW-1:0]        q_adj;

  assign diff      = DW'(cur_s) - DW'(prev_s);
  assign ph_s      = {1'b0, phase};
  assign prod_comb = TW'(diff) * TW'(ph_s);

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_comb;
      base <= prev_s;
    end
  end

  // scale back, truncating toward zero
  assign t     = (TW'(base) <<< FRAC_BITS) + prod;
  assign q     = t >>> FRAC_BITS;
  assign q_adj = q + TW'(t[TW-1] && (|t[FRAC_BITS-1:0]));

  always_comb begin
    if (q_adj > HI) begin
      y = SAMPLE_MAX;
    end else if (q_adj < LO) begin
      y = SAMPLE_MIN;
    end else begin
      y = q_adj[SAMPLE_W-1:0];
    end
  end
endmodule

>>> rtl/slr_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slr_merge
// joins the two lane results into one output item register
// ---------------------------------------------------------------------------
module slr_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  slr_pkg::slr_tag_t                   tag,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] left_y,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] right_y,
  output logic                                advance,
  slr_out_if.source                           results
);
  import slr_pkg::*;

  // pipeline moves when the output register is empty or being drained
  assign advance = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.out_left  <= left_y;
      results.out_right <= right_y;
      results.out_last  <= tag.last;
    end
  end
endmodule

>>> rtl/stereo_linear_resampler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stereo_linear_resampler_unit
// linear interpolation resampler for signed 16-bit stereo frames
// ---------------------------------------------------------------------------
// Each accepted frame carries a Q2.F phase step (1/ratio, 0 means 1.0, small
// nonzero steps are raised to 0.25). The first frame after reset is only
// stored and yields no item. Every later frame yields between zero and four
// output items, prev + (cur - prev) * phase per channel, one per cycle while
// the phase stays below 1.0 and the result channel does not stall; out_last
// marks the final item of a frame. A frame with outputs holds the input side
// until its last item is issued, since one phase value at a time is issued to
// the shared left and right lanes. An issued item passes the lane product
// register and then the output register. Backpressure on the result channel
// stalls the issue sequencer and the lanes together, while already finished
// items wait in the output register.
module stereo_linear_resampler_unit #(
  parameter int FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  slr_in_if.sink    frames,
  slr_out_if.source results
);
  import slr_pkg::*;
  `include "assert_macros.svh"

  // phase widths: stored Q3.F phase, effective step, running loop phase
  localparam int PW = FRAC_BITS + 3;
  localparam int SW = (FRAC_BITS + 1 > STEP_W) ? FRAC_BITS + 1 : STEP_W;
  localparam int LW = ((PW > SW) ? PW : SW) + 1;

  localparam logic [PW-1:0] ONE_PW   = PW'(1) << FRAC_BITS;
  localparam logic [LW-1:0] ONE      = LW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] STEP_ONE = SW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] STEP_MIN = STEP_ONE >> 2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                       state;
  logic                       primed;
  logic [PW-1:0]              phase_acc;
  logic signed [SAMPLE_W-1:0] prev_left;
  logic signed [SAMPLE_W-1:0] prev_right;
  logic signed [SAMPLE_W-1:0] cur_left;
  logic signed [SAMPLE_W-1:0] cur_right;
  logic [SW-1:0]              step_q;
  logic [LW-1:0]              lp;
  logic [CNT_W-1:0]           cnt;
  slr_tag_t                   tag;

  logic                       in_acc;
  logic [SW-1:0]              step_raw;
  logic [SW-1:0]              step_eff;
  logic [LW-1:0]              lp_sum;
  logic [LW-1:0]              lp_rem;
  logic                       issue;
  logic                       issue_last;
  logic                       advance;
  logic signed [SAMPLE_W-1:0] left_y;
  logic signed [SAMPLE_W-1:0] right_y;

  // a new frame is taken only between frames
  assign frames.ready = (state == ST_IDLE);
  assign in_acc       = frames.valid && frames.ready;

  // zero step means 1.0, tiny steps saturate to 0.25
  assign step_raw = SW'(frames.phase_step);
  always_comb begin
    if (step_raw == '0) begin
      step_eff = STEP_ONE;
    end else if (step_raw < STEP_MIN) begin
      step_eff = STEP_MIN;
    end else begin
      step_eff = step_raw;
    end
  end

  // one phase point issued per cycle while running and not stalled
  assign issue      = (state == ST_RUN) && advance;
  assign lp_sum     = lp + LW'(step_q);
  assign lp_rem     = lp_sum - ONE;
  assign issue_last = (lp_sum >= ONE) || (cnt == CNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      primed     <= 1'b0;
      phase_acc  <= '0;
      prev_left  <= '0;
      prev_right <= '0;
      cnt        <= '0;
      tag        <= '0;
    end else begin
      if (advance) begin
        tag.valid <= issue;
        tag.last  <= issue_last;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (!primed) begin
              // first frame only primes the history
              prev_left  <= frames.left_in;
              prev_right <= frames.right_in;
              phase_acc  <= '0;
              primed     <= 1'b1;
            end else if (phase_acc >= ONE_PW) begin
              // phase already past this frame: no item, just move on
              prev_left  <= frames.left_in;
              prev_right <= frames.right_in;
              phase_acc  <= phase_acc - ONE_PW;
            end else begin
              cur_left  <= frames.left_in;
              cur_right <= frames.right_in;
              step_q    <= step_eff;
              lp        <= LW'(phase_acc);
              cnt       <= '0;
              state     <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (issue_last) begin
              phase_acc  <= (lp_sum >= ONE) ? lp_rem[PW-1:0] : '0;
              prev_left  <= cur_left;
              prev_right <= cur_right;
              state      <= ST_IDLE;
            end else begin
              lp  <= lp_sum;
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // left and right lanes share the issued phase
  slr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_left (
    .clk    (clk),
    .en     (advance),
    .prev_s (prev_left),
    .cur_s  (cur_left),
    .phase  (lp[FRAC_BITS-1:0]),
    .y      (left_y)
  );

  slr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_right (
    .clk    (clk),
    .en     (advance),
    .prev_s (prev_right),
    .cur_s  (cur_right),
    .phase  (lp[FRAC_BITS-1:0]),
    .y      (right_y)
  );

  // output register and stall control
  slr_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .tag     (tag),
    .left_y  (left_y),
    .right_y (right_y),
    .advance (advance),
    .results (results)
  );

  // checks
  `SLR_CHECK(a_phase_below_one, issue |-> (lp < ONE), "issued phase not below one")
  `SLR_CHECK(a_out_bound, (issue && cnt == CNT_LAST) |-> issue_last, "too many items")
  `SLR_CHECK(a_back_to_idle, (issue && issue_last) |=> (state == ST_IDLE), "no return to idle")
  `SLR_CHECK(a_stall_holds, (tag.valid && !advance) |=> (tag.valid && $stable(tag.last)), "stage lost")
  `SLR_CHECK_NR(a_reset_clears, rst |=> (!tag.valid && !primed), "reset left state")
endmodule
